// ===== hdl/swsr_pkg.sv =====
// ============================================================================
// swsr_pkg
// Shared types and constants of the stack with search and remove unit:
// store depth, counter widths, request and status codes, item structs.
// ============================================================================
`default_nettype none

package swsr_pkg;

   // Store geometry
   localparam int DEPTH  = 128;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // Request codes
   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_REMOVE = 2'd3
   } req_code_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_code_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SCAN,
      S_SHIFT
   } state_type;

   // Input item
   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] data_value;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [7:0]               position_from_top;
      logic [1:0]               status;
      logic [7:0]               fill_level;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hdl/stack_with_search_remove_unit.sv =====
// ============================================================================
// stack_with_search_remove_unit
// Bounded LIFO stack of signed 32-bit words with push, pop, search for the
// occurrence nearest the bottom, and removal of that occurrence.
// ============================================================================
//
//  channel   | ports                    | handshake
//  ----------+--------------------------+-------------------------------------
//  request   | start, busy, req_item    | taken when start=1 and busy=0
//  result    | rsp_valid, rsp_item      | one-cycle strobe, cannot be held off
//
//  Push, and any request on an empty stack, answers in the cycle after accept.
//  Pop does one memory read, then gives the result.
//  Search reads the entries from the bottom up to the match (at most the
//  fill level of them), one read per cycle.
//  Remove then moves each entry above the match one place lower, each a read
//  and a write back through the single-read, single-write store.
//  Reset is synchronous and empties the stack at once; no clearing pass.
//  busy is high while a request is in progress; the receiver never stalls.
// ============================================================================
`default_nettype none

module stack_with_search_remove_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  swsr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output swsr_pkg::rsp_item_type rsp_item
);

   // Store and its ports
   logic [swsr_pkg::DATA_W-1:0] store_mem [swsr_pkg::DEPTH];
   logic                        rd_en;
   logic [swsr_pkg::ADDR_W-1:0] rd_addr;
   logic [swsr_pkg::DATA_W-1:0] rd_data_ff;
   logic                        wr_en;
   logic [swsr_pkg::ADDR_W-1:0] wr_addr;
   logic [swsr_pkg::DATA_W-1:0] wr_data;

   // Control and working registers
   swsr_pkg::state_type        state_ff, state_in;
   logic [swsr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [swsr_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [swsr_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [swsr_pkg::DATA_W-1:0] val_ff, val_in;
   logic                       rem_ff, rem_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   swsr_pkg::rsp_item_type     rsp_ff, rsp_in;

   logic [swsr_pkg::CNT_W-1:0] idx_next;
   logic [swsr_pkg::CNT_W-1:0] pos_now;
   logic                       last_entry;
   logic                       hit;

   assign idx_next   = swsr_pkg::CNT_W'(idx_ff + 1'b1);
   assign pos_now    = swsr_pkg::CNT_W'(count_ff - idx_ff);
   assign last_entry = (idx_next == count_ff);
   assign hit        = (rd_data_ff == val_ff);

   assign busy      = (state_ff != swsr_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swsr_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   // Sequencer: next state, memory commands and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      unique case (state_ff)
         swsr_pkg::S_IDLE: begin
            if (start) begin
               val_in = req_item.data_value;
               rem_in = (req_item.req_type == swsr_pkg::REQ_REMOVE);
               unique case (swsr_pkg::req_code_type'(req_item.req_type))
                  swsr_pkg::REQ_PUSH: begin
                     // write on top, or refuse when full
                     rsp_valid_in = 1'b1;
                     if (count_ff == swsr_pkg::CNT_W'(swsr_pkg::DEPTH)) begin
                        rsp_in.status = swsr_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[swsr_pkg::ADDR_W-1:0];
                        wr_data  = req_item.data_value;
                        count_in = swsr_pkg::CNT_W'(count_ff + 1'b1);
                     end
                  end
                  swsr_pkg::REQ_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = swsr_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = swsr_pkg::ADDR_W'(count_ff - 1'b1);
                        state_in = swsr_pkg::S_POP;
                     end
                  end
                  swsr_pkg::REQ_SEARCH, swsr_pkg::REQ_REMOVE: begin
                     // walk up from the bottom
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = swsr_pkg::ST_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = swsr_pkg::S_SCAN;
                     end
                  end
               endcase
            end
         end

         swsr_pkg::S_POP: begin
            count_in          = swsr_pkg::CNT_W'(count_ff - 1'b1);
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = rd_data_ff;
            state_in          = swsr_pkg::S_IDLE;
         end

         swsr_pkg::S_SCAN: begin
            if (hit) begin
               pos_in = pos_now;
               if (!rem_ff || last_entry) begin
                  // done: plain search, or removal of the top entry
                  if (rem_ff) begin
                     count_in = swsr_pkg::CNT_W'(count_ff - 1'b1);
                  end
                  rsp_valid_in             = 1'b1;
                  rsp_in.position_from_top = 8'(pos_now);
                  state_in                 = swsr_pkg::S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_next[swsr_pkg::ADDR_W-1:0];
                  idx_in   = idx_next;
                  state_in = swsr_pkg::S_SHIFT;
               end
            end else if (last_entry) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = swsr_pkg::ST_NOT_FOUND;
               state_in      = swsr_pkg::S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_next[swsr_pkg::ADDR_W-1:0];
               idx_in  = idx_next;
            end
         end

         swsr_pkg::S_SHIFT: begin
            // move the entry read last cycle down one place
            wr_en   = 1'b1;
            wr_addr = swsr_pkg::ADDR_W'(idx_ff - 1'b1);
            wr_data = rd_data_ff;
            if (last_entry) begin
               count_in                 = swsr_pkg::CNT_W'(count_ff - 1'b1);
               rsp_valid_in             = 1'b1;
               rsp_in.position_from_top = 8'(pos_ff);
               state_in                 = swsr_pkg::S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_next[swsr_pkg::ADDR_W-1:0];
               idx_in  = idx_next;
            end
         end
      endcase

      rsp_in.fill_level = 8'(count_in);
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= swsr_pkg::CNT_W'(swsr_pkg::DEPTH))
      else $error("entry count above depth");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start) || $past(state_ff != swsr_pkg::S_IDLE))
      else $error("result without a request in progress");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == swsr_pkg::ST_FULL
      |-> count_ff == swsr_pkg::CNT_W'(swsr_pkg::DEPTH))
      else $error("full status on a stack that is not full");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == swsr_pkg::S_SHIFT |-> idx_ff != '0 && idx_ff < count_ff)
      else $error("shift index out of range");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == swsr_pkg::S_POP |=> swsr_pkg::CNT_W'(count_ff + 1'b1) == $past(count_ff))
      else $error("pop did not lower the count by one");

endmodule

`default_nettype wire
